/* rtl/tkfl_pkg.sv */
// Shared types and codes for the top-k frequency list.
`timescale 1ns / 1ps

package tkfl_pkg;

	localparam int LIST_DEPTH_DEF = 16;
	localparam int ID_W           = 16;
	localparam int KEY_W          = 16;
	localparam int INDEX_W        = 4;
	localparam int COUNT_W        = 5;

	// Item kinds.
	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [KEY_W-1:0] key;
	} entry_t;

	// Broadcast from the sequencer to every cell of the chain.
	typedef struct packed {
		logic   swap;
		logic   clear;
		entry_t new_entry;
	} cell_ctl_t;

endpackage

/* rtl/tkfl_cell.sv */
// One slot of the sorted list: holds an entry and the moving-entry mark.
`timescale 1ns / 1ps

module tkfl_cell
	import tkfl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      load,
	input  entry_t    upper_entry,
	input  entry_t    lower_entry,
	input  logic      lower_mark,
	output entry_t    entry,
	output logic      mark,
	output logic      swap_req
);

	entry_t entry_q;
	logic   mark_q;

	// The marked entry trades places with its upper neighbor while its key is larger.
	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= ctl.new_entry;
		end else if (ctl.swap && mark_q) begin
			entry_q <= upper_entry;
		end else if (ctl.swap && lower_mark) begin
			entry_q <= lower_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= 1'b0;
		end else if (load) begin
			mark_q <= 1'b1;
		end else if (ctl.clear) begin
			mark_q <= 1'b0;
		end else if (ctl.swap) begin
			mark_q <= lower_mark;
		end
	end

	assign entry    = entry_q;
	assign mark     = mark_q;
	assign swap_req = mark_q && (entry_q.key > upper_entry.key);

endmodule

/* rtl/top_k_frequency_list.sv */
// Top level of the top-k frequency list: a chain of list cells and its sequencer.
`timescale 1ns / 1ps

// Channel   Signals                                      Transfer
// --------  -------------------------------------------  --------------------------
// command   start, busy, kind, song_id, frequency, index  start high and busy low
// result    done, placed, position, list_size,            done high, one cycle,
//           read_id, read_key, read_valid                 cannot be held off
//
// A read, or an add that does not enter the list, gives its result in the cycle after
// the transfer and busy stays low, so such items may follow each other every cycle.
// An add that places its entry loads and marks it in its cell and holds busy high
// while it climbs 0 to LIST_DEPTH-1 slots: the marked entry moves up one cell per
// cycle by swapping with its neighbor, and done rises once a check finds it settled.
// Reset only empties the list (fill count to zero); no clearing pass is needed
// since only entries below the fill count are ever looked at.
module top_k_frequency_list
	import tkfl_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [ID_W-1:0]    song_id,
	input  logic [KEY_W-1:0]   frequency,
	input  logic [INDEX_W-1:0] index,
	output logic               done,
	output logic               placed,
	output logic [COUNT_W-1:0] position,
	output logic [COUNT_W-1:0] list_size,
	output logic [ID_W-1:0]    read_id,
	output logic [KEY_W-1:0]   read_key,
	output logic               read_valid
);

	// Slot index width and fill count width follow the depth.
	localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam logic [COUNT_W-1:0] NOT_PLACED = COUNT_W'(LIST_DEPTH);

	typedef enum logic {
		ST_IDLE,
		ST_MOVE
	} state_t;

	state_t              state_q;
	logic                done_q;
	logic                placed_q;
	logic [COUNT_W-1:0]  position_q;
	logic [ID_W-1:0]     read_id_q;
	logic [KEY_W-1:0]    read_key_q;
	logic                read_valid_q;
	logic [CW-1:0]       fill_q;
	logic [IW-1:0]       pos_q;

	entry_t                cell_entry [LIST_DEPTH];
	logic [LIST_DEPTH-1:0] cell_mark;
	logic [LIST_DEPTH-1:0] cell_swap_req;
	logic [LIST_DEPTH-1:0] cell_load;
	logic [LIST_DEPTH-1:0] match;
	cell_ctl_t             ctl;

	logic          accept;
	logic          found;
	logic          full;
	logic          beat;
	logic          place;
	logic          grow;
	logic          any_swap;
	logic [IW-1:0] match_idx;
	logic [IW-1:0] load_idx;
	entry_t        rd_entry;
	logic          rd_ok;

	assign busy   = (state_q == ST_MOVE);
	assign accept = start && !busy;

	// Look up the identifier in every filled cell at once; identifiers are unique
	// in the list, so at most one cell matches and an OR of indexes encodes it.
	always_comb begin
		match_idx = '0;
		for (int j = 0; j < LIST_DEPTH; j++) begin
			match[j] = (32'(j) < 32'(fill_q)) && (cell_entry[j].id == song_id);
			if (match[j]) begin
				match_idx = match_idx | IW'(j);
			end
		end
	end

	// Read port: a select over the cells at the requested index.
	always_comb begin
		rd_entry = '0;
		for (int j = 0; j < LIST_DEPTH; j++) begin
			if (32'(j) == 32'(index)) begin
				rd_entry = cell_entry[j];
			end
		end
		rd_ok = 32'(index) < 32'(fill_q);
	end

	// An add lands either on its own listed cell, on the first free cell, or on
	// the last cell when the list is full and its key beats the last entry.
	assign found = |match;
	assign full  = (32'(fill_q) == 32'(LIST_DEPTH));
	assign beat  = full && (frequency > cell_entry[LIST_DEPTH-1].key);
	assign place = accept && (kind == KIND_ADD) && (found || !full || beat);
	assign grow  = !found && !full;

	always_comb begin
		if (found) begin
			load_idx = match_idx;
		end else if (!full) begin
			load_idx = IW'(fill_q);
		end else begin
			load_idx = IW'(LIST_DEPTH - 1);
		end
		for (int j = 0; j < LIST_DEPTH; j++) begin
			cell_load[j] = place && (32'(j) == 32'(load_idx));
		end
	end

	assign any_swap          = |cell_swap_req;
	assign ctl.swap          = (state_q == ST_MOVE) && any_swap;
	assign ctl.clear         = (state_q == ST_MOVE) && !any_swap;
	assign ctl.new_entry.id  = song_id;
	assign ctl.new_entry.key = frequency;

	// The chain: each cell sees its upper and lower neighbor. The top cell compares
	// against itself, so it never asks to swap.
	for (genvar j = 0; j < LIST_DEPTH; j++) begin : g_cell
		entry_t up_entry;
		entry_t dn_entry;
		logic   dn_mark;

		if (j == 0) begin : g_top
			assign up_entry = cell_entry[j];
		end else begin : g_mid
			assign up_entry = cell_entry[j-1];
		end

		if (j == LIST_DEPTH - 1) begin : g_bottom
			assign dn_entry = '0;
			assign dn_mark  = 1'b0;
		end else begin : g_inner
			assign dn_entry = cell_entry[j+1];
			assign dn_mark  = cell_mark[j+1];
		end

		tkfl_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.load        (cell_load[j]),
			.upper_entry (up_entry),
			.lower_entry (dn_entry),
			.lower_mark  (dn_mark),
			.entry       (cell_entry[j]),
			.mark        (cell_mark[j]),
			.swap_req    (cell_swap_req[j])
		);
	end

	// Sequencer: takes items, follows the climbing entry, and issues each result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done_q       <= 1'b0;
			placed_q     <= 1'b0;
			position_q   <= '0;
			read_id_q    <= '0;
			read_key_q   <= '0;
			read_valid_q <= 1'b0;
			fill_q       <= '0;
			pos_q        <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (kind == KIND_READ) begin
							done_q       <= 1'b1;
							placed_q     <= 1'b0;
							position_q   <= NOT_PLACED;
							read_id_q    <= rd_ok ? rd_entry.id : '0;
							read_key_q   <= rd_ok ? rd_entry.key : '0;
							read_valid_q <= rd_ok;
						end else begin
							read_id_q    <= '0;
							read_key_q   <= '0;
							read_valid_q <= 1'b0;
							if (place) begin
								state_q <= ST_MOVE;
								pos_q   <= load_idx;
								if (grow) begin
									fill_q <= fill_q + CW'(1);
								end
							end else begin
								done_q     <= 1'b1;
								placed_q   <= 1'b0;
								position_q <= NOT_PLACED;
							end
						end
					end
				end
				ST_MOVE: begin
					if (any_swap) begin
						pos_q <= pos_q - IW'(1);
					end else begin
						state_q    <= ST_IDLE;
						done_q     <= 1'b1;
						placed_q   <= 1'b1;
						position_q <= COUNT_W'(pos_q);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign placed     = placed_q;
	assign position   = position_q;
	assign list_size  = COUNT_W'(fill_q);
	assign read_id    = read_id_q;
	assign read_key   = read_key_q;
	assign read_valid = read_valid_q;

endmodule

/* test/tkfl_checker.sv */
// Checker for the top-k frequency list: mirrors the ranking and compares every result.
`timescale 1ns / 1ps

module tkfl_checker
	import tkfl_pkg::*;
#(
	parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               kind,
	input  logic [ID_W-1:0]    song_id,
	input  logic [KEY_W-1:0]   frequency,
	input  logic [INDEX_W-1:0] index,
	input  logic               done,
	input  logic               placed,
	input  logic [COUNT_W-1:0] position,
	input  logic [COUNT_W-1:0] list_size,
	input  logic [ID_W-1:0]    read_id,
	input  logic [KEY_W-1:0]   read_key,
	input  logic               read_valid,
	output int                 fail_count,
	output int                 pending,
	output int                 adds_placed,
	output int                 adds_rejected,
	output int                 reads_total,
	output int                 reads_hit
);

	typedef struct packed {
		logic               placed;
		logic [COUNT_W-1:0] position;
		logic [COUNT_W-1:0] list_size;
		logic [ID_W-1:0]    read_id;
		logic [KEY_W-1:0]   read_key;
		logic               read_valid;
	} rank_result_t;

	entry_t       ranked [LIST_DEPTH];
	int           ranked_count;
	rank_result_t rank_results_q [$];

	// Move the entry at slot up past strictly smaller keys and return where it settles.
	function automatic int climb_entry(int slot);
		entry_t held;
		while (slot > 0 && ranked[slot].key > ranked[slot-1].key) begin
			held           = ranked[slot-1];
			ranked[slot-1] = ranked[slot];
			ranked[slot]   = held;
			slot--;
		end
		return slot;
	endfunction

	function automatic rank_result_t rank_update(logic k, logic [ID_W-1:0] id,
			logic [KEY_W-1:0] key, logic [INDEX_W-1:0] idx);
		rank_result_t r;
		int           hit_slot;
		int           slot;
		r          = '0;
		r.position = COUNT_W'(LIST_DEPTH);
		slot       = 0;
		if (k == KIND_READ) begin
			if (int'(idx) < ranked_count && int'(idx) < LIST_DEPTH) begin
				r.read_id    = ranked[idx].id;
				r.read_key   = ranked[idx].key;
				r.read_valid = 1'b1;
			end
		end else begin
			hit_slot = -1;
			for (int i = 0; i < ranked_count; i++) begin
				if (ranked[i].id == id)
					hit_slot = i;
			end
			if (hit_slot >= 0) begin
				ranked[hit_slot].key = key;
				slot                 = climb_entry(hit_slot);
				r.placed             = 1'b1;
			end else if (ranked_count < LIST_DEPTH) begin
				ranked[ranked_count].id  = id;
				ranked[ranked_count].key = key;
				ranked_count++;
				slot     = climb_entry(ranked_count - 1);
				r.placed = 1'b1;
			end else if (key > ranked[LIST_DEPTH-1].key) begin
				ranked[LIST_DEPTH-1].id  = id;
				ranked[LIST_DEPTH-1].key = key;
				slot     = climb_entry(LIST_DEPTH - 1);
				r.placed = 1'b1;
			end
			if (r.placed)
				r.position = COUNT_W'(slot);
		end
		r.list_size = COUNT_W'(ranked_count);
		return r;
	endfunction

	task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		rank_result_t want;
		if (!arst_n) begin
			ranked_count = 0;
			rank_results_q.delete();
			fail_count    = 0;
			pending       = 0;
			adds_placed   = 0;
			adds_rejected = 0;
			reads_total   = 0;
			reads_hit     = 0;
		end else begin
			// The new expectation goes in first so that the oldest one is still popped below.
			if (start && !busy) begin
				want = rank_update(kind, song_id, frequency, index);
				rank_results_q.push_back(want);
				if (kind == KIND_READ) begin
					reads_total++;
					if (want.read_valid)
						reads_hit++;
				end else if (want.placed) begin
					adds_placed++;
				end else begin
					adds_rejected++;
				end
			end
			if (done) begin
				if (rank_results_q.size() == 0) begin
					$display("%0t: result with no transfer waiting, expected none,",
						$time);
					$display("    actual placed=%0d position=%0d", placed, position);
					fail_count++;
				end else begin
					want = rank_results_q.pop_front();
					compare_field("placed", 32'(want.placed), 32'(placed));
					compare_field("position", 32'(want.position), 32'(position));
					compare_field("list_size", 32'(want.list_size), 32'(list_size));
					compare_field("read_id", 32'(want.read_id), 32'(read_id));
					compare_field("read_key", 32'(want.read_key), 32'(read_key));
					compare_field("read_valid", 32'(want.read_valid), 32'(read_valid));
				end
			end
			pending = rank_results_q.size();
		end
	end

endmodule

/* test/tb_top_k_frequency_list.sv */
// Testbench top for the top-k frequency list: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top_k_frequency_list;
	import tkfl_pkg::*;

	localparam int DEPTH        = LIST_DEPTH_DEF;
	localparam int RANDOM_ITEMS = 1450;
	// Base of the small identifier pool; the directed fill uses the same range so that
	// random adds keep hitting identifiers that are already listed.
	localparam logic [ID_W-1:0] POOL_BASE = 16'h0100;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               kind;
	logic [ID_W-1:0]    song_id;
	logic [KEY_W-1:0]   frequency;
	logic [INDEX_W-1:0] index;
	logic               done;
	logic               placed;
	logic [COUNT_W-1:0] position;
	logic [COUNT_W-1:0] list_size;
	logic [ID_W-1:0]    read_id;
	logic [KEY_W-1:0]   read_key;
	logic               read_valid;

	int fail_count;
	int pending;
	int adds_placed;
	int adds_rejected;
	int reads_total;
	int reads_hit;

	// Transfers left in the current burst of the sender.
	int burst_left;

	top_k_frequency_list #(
		.LIST_DEPTH(DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.kind      (kind),
		.song_id   (song_id),
		.frequency (frequency),
		.index     (index),
		.done      (done),
		.placed    (placed),
		.position  (position),
		.list_size (list_size),
		.read_id   (read_id),
		.read_key  (read_key),
		.read_valid(read_valid)
	);

	// The checker sees exactly what the block sees and keeps its own copy of the ranking.
	tkfl_checker #(
		.LIST_DEPTH(DEPTH)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.song_id      (song_id),
		.frequency    (frequency),
		.index        (index),
		.done         (done),
		.placed       (placed),
		.position     (position),
		.list_size    (list_size),
		.read_id      (read_id),
		.read_key     (read_key),
		.read_valid   (read_valid),
		.fail_count   (fail_count),
		.pending      (pending),
		.adds_placed  (adds_placed),
		.adds_rejected(adds_rejected),
		.reads_total  (reads_total),
		.reads_hit    (reads_hit)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Hard stop in case the block hangs with busy high or never returns a result.
	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Lower start for a number of cycles. The fields carry noise meanwhile, which the
	// block must ignore since no transfer takes place.
	task automatic idle_gap(int cycles);
		if (cycles > 0) begin
			@(negedge clk);
			start     <= 1'b0;
			kind      <= 1'($urandom);
			song_id   <= ID_W'($urandom);
			frequency <= KEY_W'($urandom);
			index     <= INDEX_W'($urandom);
			repeat (cycles - 1) @(negedge clk);
		end
	endtask

	// Offer one item and hold it until the block takes it. Inputs change at the falling
	// edge; busy is looked at right after the rising edge, which still shows the value
	// the block had at that edge. start stays high when the next item follows directly.
	task automatic send_item(logic k, logic [ID_W-1:0] id, logic [KEY_W-1:0] key,
			logic [INDEX_W-1:0] idx);
		if (burst_left == 0) begin
			idle_gap($urandom_range(1, 6));
			// Mostly short bursts, now and then a long stretch without any gap.
			if ($urandom_range(0, 7) == 0)
				burst_left = $urandom_range(30, 80);
			else
				burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		start     <= 1'b1;
		kind      <= k;
		song_id   <= id;
		frequency <= key;
		index     <= idx;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		int               waited;
		logic             r_kind;
		logic [ID_W-1:0]  r_id;
		logic [KEY_W-1:0] r_key;
		int               pick;

		arst_n     = 1'b0;
		start      = 1'b0;
		kind       = KIND_ADD;
		song_id    = '0;
		frequency  = '0;
		index      = '0;
		burst_left = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed part. Reads of an empty list come back invalid and zero.
		send_item(KIND_READ, '0, '0, 4'd0);
		send_item(KIND_READ, '1, '1, 4'd15);
		// Smallest identifier and key, then the largest of both, which climbs to the top.
		send_item(KIND_ADD, 16'h0000, 16'h0000, '0);
		send_item(KIND_ADD, 16'hFFFF, 16'hFFFF, '1);
		// A tie with the lowest key stays behind the older entry.
		send_item(KIND_ADD, 16'h1234, 16'h0000, '0);
		send_item(KIND_READ, '0, '0, 4'd0);
		send_item(KIND_READ, '0, '0, 4'd3);
		// An update to a key equal to the top does not pass it; a lowered key stays put.
		send_item(KIND_ADD, 16'h0000, 16'hFFFF, '0);
		send_item(KIND_ADD, 16'hFFFF, 16'h0000, '0);
		// Fill the rest of the list with rising keys, each climbing a bit further.
		for (int i = 0; i < DEPTH - 3; i++)
			send_item(KIND_ADD, POOL_BASE + ID_W'(i), KEY_W'(i * 1000 + 1), '0);
		// Full list: a key that does not beat the last entry is turned away, while the
		// largest key evicts the last entry and climbs until it meets the entry with the same key.
		send_item(KIND_ADD, 16'h4321, 16'h0000, '0);
		send_item(KIND_ADD, 16'h5678, 16'hFFFF, '0);
		send_item(KIND_READ, '0, '0, 4'd15);

		// Random part. Most adds draw from a small pool of identifiers so that updates,
		// evictions and re-entries are frequent; the rest use any identifier. Keys are
		// often from a narrow range to produce ties, sometimes at the extremes.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			r_kind = ($urandom_range(0, 3) == 0) ? KIND_READ : KIND_ADD;
			if ($urandom_range(0, 6) == 0)
				r_id = ID_W'($urandom);
			else
				r_id = POOL_BASE + ID_W'($urandom_range(0, 23));
			pick = $urandom_range(0, 9);
			if (pick < 3)
				r_key = KEY_W'($urandom_range(0, 7));
			else if (pick == 3)
				r_key = '0;
			else if (pick == 4)
				r_key = '1;
			else
				r_key = KEY_W'($urandom);
			send_item(r_kind, r_id, r_key, INDEX_W'($urandom_range(0, 15)));
		end

		@(negedge clk);
		start <= 1'b0;

		// Wait for the last results, then allow for a full climb before the verdict.
		waited = 0;
		while (pending != 0 && waited < 2000) begin
			@(negedge clk);
			waited++;
		end
		if (pending != 0) begin
			$display("%0t: %0d results never arrived", $time, pending);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			repeat (2 * DEPTH + 8) @(negedge clk);
			$display("Ran %0d adds (%0d ranked, %0d turned away from a full list)",
				adds_placed + adds_rejected, adds_placed, adds_rejected);
			$display("and %0d reads (%0d inside the list), with random sender gaps.",
				reads_total, reads_hit);
			if (fail_count == 0 && pending == 0)
				$display("ALL CHECKS PASSED");
			else
				$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule
